// ===== hw/rtl/running_top_k_frequent_macros.svh =====
// assertion macros for the running top-k frequent block
`ifndef RUNNING_TOP_K_FREQUENT_MACROS_SVH
`define RUNNING_TOP_K_FREQUENT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RTKF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtkf assertion failed");

// next-cycle implication, disabled in reset
`define RTKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtkf assertion failed");

`endif

// ===== hw/rtl/rtkf_pkg.sv =====
// package with constants and types of the running top-k frequent block
`timescale 1ns / 1ps

package rtkf_pkg;

    localparam int VALUE_W    = 10;
    localparam int COUNT_W    = 16;
    localparam int LIST_MAX   = 16;
    localparam int SLOTS      = LIST_MAX + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int RANK_W     = 4;
    localparam int K_W        = $clog2(SLOTS + 1);
    localparam int TOP_W      = 5;
    localparam int EPOCH_W    = 4;
    localparam int ADDR_W     = VALUE_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int MEM_W      = EPOCH_W + COUNT_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TOP_W-1:0]        TOP_COUNT_RESET = TOP_W'(4);
    localparam logic [COUNT_W-1:0]      COUNT_MAX       = '1;
    localparam logic [EPOCH_W-1:0]      EPOCH_MAX       = '1;
    localparam logic [ADDR_W-1:0]       ADDR_MAX        = '1;
    localparam logic [CFG_ADDR_W-3:0]   REG_TOP_COUNT   = '0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_BUBBLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               clear;
        logic               insert;
        logic               step;
        logic [K_W-1:0]     k;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_rank_ctrl;

    typedef struct packed {
        logic           moving;
        logic [K_W-1:0] emit_n;
    } t_rank_stat;

endpackage

// ===== hw/rtl/rtkf_channels.sv =====
// handshake channel interfaces for input items and ranked results
`timescale 1ns / 1ps

interface rtkf_in_if;
    import rtkf_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               end_of_sequence;

    modport source (output valid, output value, output end_of_sequence, input ready);
    modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface rtkf_out_if;
    import rtkf_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  rank;
    logic [VALUE_W-1:0] ranked_value;
    logic               last;

    modport source (output valid, output rank, output ranked_value, output last, input ready);
    modport sink   (input valid, input rank, input ranked_value, input last, output ready);
endinterface

// ===== hw/rtl/running_top_k_frequent.sv =====
// top level of the running top-k frequent block: count memory, sequencer, output and config
//
//  channel  dir  kind        payload
//  i_in     in   valid/ready value, end_of_sequence
//  o_out    out  valid/ready rank, ranked_value, last
//  apb      in   apb write   top_count at byte address 0
//
// an item passes through the read, bubble and emit states: s bubble swaps at one slot swap per cycle,
// n results at one transaction per cycle through the output register while the output does not stall
// a zero value skips the count read-modify-write and the bubble
// after reset, and after every 16th end of sequence, a pass over all 1024 addresses clears the count memory
// a stalled output holds the sequencer only while the output register is full
`timescale 1ns / 1ps
`include "running_top_k_frequent_macros.svh"

module running_top_k_frequent (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rtkf_in_if.sink                           i_in,
    rtkf_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtkf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [rtkf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rtkf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rtkf_pkg::*;

    t_state             r_state;
    t_state             n_state;

    logic [TOP_W-1:0]   r_top_count;
    logic [K_W-1:0]     r_k;
    logic [VALUE_W-1:0] r_value;
    logic               r_eos;
    logic [EPOCH_W-1:0] r_epoch;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [RANK_W-1:0]  r_j;

    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_rank;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;

    logic [MEM_W-1:0]   r_mem [MEM_DEPTH];
    logic [MEM_W-1:0]   r_rdata;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;

    logic               cfg_hit;
    logic               in_ready;
    logic               accept;
    logic [K_W-1:0]     k_sat;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] new_count;
    logic [K_W-1:0]     j_plus;
    logic               out_free;
    logic               out_load;
    logic               j_inc;
    logic               finish;

    t_rank_ctrl         ctrl;
    t_rank_stat         stat;
    logic [VALUE_W-1:0] rd_value;

    // configuration port
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_TOP_COUNT);
    assign pready  = 1'b1;
    assign prdata  = (psel && cfg_hit) ? CFG_DATA_W'(r_top_count) : '0;

    assign k_sat = (r_top_count > TOP_W'(LIST_MAX)) ? K_W'(LIST_MAX) : K_W'(r_top_count);

    // count memory with epoch tag
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[i_in.value];
    end

    assign cur_count = (r_rdata[MEM_W-1 -: EPOCH_W] == r_epoch) ? r_rdata[COUNT_W-1:0] : '0;
    assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);

    assign accept   = in_ready && i_in.valid;
    assign j_plus   = K_W'(r_j) + K_W'(1);
    assign out_free = !r_out_valid || o_out.ready;

    rtkf_ranker u_ranker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_rd_idx   (r_j),
        .o_stat     (stat),
        .o_rd_value (rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        in_ready    = 1'b0;
        ctrl        = '0;
        ctrl.k      = r_k;
        ctrl.value  = r_value;
        ctrl.count  = new_count;
        mem_we      = 1'b0;
        mem_waddr   = r_value;
        mem_wdata   = {r_epoch, new_count};
        out_load    = 1'b0;
        j_inc       = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == ADDR_MAX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = (i_in.value != '0) ? S_READ : S_EMIT;
                end
            end
            S_READ: begin
                mem_we      = 1'b1;
                ctrl.insert = 1'b1;
                n_state     = S_BUBBLE;
            end
            S_BUBBLE: begin
                ctrl.step = 1'b1;
                if (!stat.moving) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.emit_n == '0) begin
                    finish = 1'b1;
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (j_plus == stat.emit_n) begin
                        finish = 1'b1;
                    end else begin
                        j_inc = 1'b1;
                    end
                end
                if (finish) begin
                    ctrl.clear = r_eos;
                    n_state    = (r_eos && (r_epoch == EPOCH_MAX)) ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_COUNT_RESET;
            r_k         <= '0;
            r_epoch     <= '0;
            r_clr_addr  <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && cfg_hit) begin
                r_top_count <= pwdata[TOP_W-1:0];
            end
            if (accept) begin
                r_k <= k_sat;
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (finish && r_eos) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (finish) begin
                r_j <= '0;
            end else if (j_inc) begin
                r_j <= r_j + RANK_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_in.value;
            r_eos   <= i_in.end_of_sequence;
        end
        if (out_load) begin
            r_out_rank  <= r_j;
            r_out_value <= rd_value;
            r_out_last  <= (j_plus == stat.emit_n);
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.rank         = r_out_rank;
    assign o_out.ranked_value = r_out_value;
    assign o_out.last         = r_out_last;

    `RTKF_ASSERT_IMPLY(a_rank_below_k, i_clk, i_rst_n, r_out_valid, K_W'(r_out_rank) < r_k)
    `RTKF_ASSERT_NEXT(a_eos_empties_list, i_clk, i_rst_n, finish && r_eos, stat.emit_n == '0)
    `RTKF_ASSERT_IMPLY(a_idle_after_last, i_clk, i_rst_n, (r_state == S_IDLE) && r_out_valid, r_out_last)

endmodule

// ===== hw/rtl/rtkf_ranker.sv =====
// ranked slot list with cached counts, first-match search and one bubble swap per cycle while step is set
`timescale 1ns / 1ps

module rtkf_ranker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtkf_pkg::t_rank_ctrl          i_ctrl,
    input  logic [rtkf_pkg::RANK_W-1:0]   i_rd_idx,
    output rtkf_pkg::t_rank_stat          o_stat,
    output logic [rtkf_pkg::VALUE_W-1:0]  o_rd_value
);
    import rtkf_pkg::*;

    logic [VALUE_W-1:0] r_val [SLOTS];
    logic [COUNT_W-1:0] r_cnt [SLOTS];
    logic [SLOTS-1:0]   r_pos;

    logic [SLOTS-1:0]   match;
    logic [SLOTS-1:0]   first;
    logic [SLOTS-1:0]   swap;
    logic [SLOTS:0]     nonzero;
    logic [SLOTS:0]     zero_oh;
    logic [K_W-1:0]     lead;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = (K_W'(i) == i_ctrl.k) ||
                       ((K_W'(i) < i_ctrl.k) && (r_val[i] == i_ctrl.value));
        end
        first = match & (~match + SLOTS'(1));

        swap[0] = 1'b0;
        for (int i = 1; i < SLOTS; i++) begin
            swap[i] = r_pos[i] && ((r_cnt[i-1] < r_cnt[i]) ||
                      ((r_cnt[i-1] == r_cnt[i]) && (r_val[i-1] > r_val[i])));
        end

        nonzero[SLOTS] = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            nonzero[i] = (r_val[i] != '0);
        end
        zero_oh = ~nonzero & (nonzero + (SLOTS + 1)'(1));
        lead = '0;
        for (int i = 0; i <= SLOTS; i++) begin
            if (zero_oh[i]) begin
                lead = lead | K_W'(i);
            end
        end

        o_stat.moving = |swap;
        o_stat.emit_n = (lead < i_ctrl.k) ? lead : i_ctrl.k;
    end

    assign o_rd_value = r_val[SLOT_W'(i_rd_idx)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_val[i] <= '0;
                r_cnt[i] <= '0;
            end
            r_pos <= '0;
        end else if (i_ctrl.insert) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (K_W'(i) == i_ctrl.k) begin
                    r_val[i] <= i_ctrl.value;
                    r_cnt[i] <= i_ctrl.count;
                end else if (r_val[i] == i_ctrl.value) begin
                    r_cnt[i] <= i_ctrl.count;
                end
            end
            r_pos <= first;
        end else if (i_ctrl.step && o_stat.moving) begin
            for (int i = 1; i < SLOTS; i++) begin
                if (swap[i]) begin
                    r_val[i-1] <= r_val[i];
                    r_val[i]   <= r_val[i-1];
                    r_cnt[i-1] <= r_cnt[i];
                    r_cnt[i]   <= r_cnt[i-1];
                end
            end
            r_pos <= r_pos >> 1;
        end
    end

endmodule
